### rtl/b64_pkg.sv
// package: shared types, constants and alphabet functions for the base64 codec
`timescale 1ns / 1ps
package b64_pkg;

  localparam logic [6:0] NOT_IN_ALPHABET = 7'd64;
  localparam int unsigned APB_AW = 3;

  // one burst of up to four result words, first word in the top byte
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  cnt;
    logic        last;
    logic        no_data;
    logic        bad_char;
  } load_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)       enc_char = w + 8'd65;
    else if (v < 6'd52)  enc_char = w + 8'd71;
    else if (v < 6'd62)  enc_char = w - 8'd4;
    else if (v == 6'd62) enc_char = 8'd43;
    else                 enc_char = 8'd47;
  endfunction

  function automatic logic [6:0] char_value(input logic [7:0] c);
    if (c >= 8'd65 && c <= 8'd90)       char_value = 7'(c - 8'd65);
    else if (c >= 8'd97 && c <= 8'd122) char_value = 7'(c - 8'd71);
    else if (c >= 8'd48 && c <= 8'd57)  char_value = 7'(c + 8'd4);
    else if (c == 8'd43)                char_value = 7'd62;
    else if (c == 8'd47)                char_value = 7'd63;
    else                                char_value = NOT_IN_ALPHABET;
  endfunction

endpackage

### rtl/b64_if.sv
// interfaces: input and result word channels
`timescale 1ns / 1ps
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       no_data;
  logic       bad_char;
  modport source (output valid, output out_byte, output out_last, output no_data,
                  output bad_char, input ready);
  modport sink (input valid, input out_byte, input out_last, input no_data,
                input bad_char, output ready);
endinterface

### rtl/b64_obuf.sv
// result buffer: holds one burst and shifts it out a word per cycle while out_ch is ready
`timescale 1ns / 1ps
module b64_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  b64_pkg::load_t load_data,
  output logic          can_load,
  b64_out_if.source     out_ch
);

  logic [31:0] data;
  logic [2:0]  cnt;
  logic        last;
  logic        no_data;
  logic        bad_char;
  logic        pop;

  assign pop      = out_ch.valid && out_ch.ready;
  assign can_load = (cnt == 3'd0) || (pop && cnt == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= load_data.cnt;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data     <= load_data.bytes;
      last     <= load_data.last;
      no_data  <= load_data.no_data;
      bad_char <= load_data.bad_char;
    end else if (pop) begin
      data <= {data[23:0], 8'h00};
    end
  end

  assign out_ch.valid    = cnt != 3'd0;
  assign out_ch.out_byte = data[31:24];
  assign out_ch.out_last = last && cnt == 3'd1;
  assign out_ch.no_data  = no_data;
  assign out_ch.bad_char = bad_char;

endmodule

### rtl/base64_unpadded_codec.sv
// top level: streaming base64 codec without padding, apb mode register
//
//  channel  dir  words          payload
//  in_ch    in   byte or char   in_byte, in_last
//  out_ch   out  char or byte   out_byte, out_last, no_data, bad_char
//  apb      in   mode write     decode_mode at address 0
//
// an item is folded into the group state in the cycle it is accepted
// an item is taken only while the result buffer is empty or sends its final word
// so an item that gives result words keeps the next item out until its final word is taken
// a stalled out_ch holds the current burst and the input waits behind it
// rst is synchronous and clears mode, group, discard flag and result buffer
`timescale 1ns / 1ps
module base64_unpadded_codec (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [b64_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  b64_in_if.sink                       in_ch,
  b64_out_if.source                    out_ch
);

  logic        decode_mode;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic        discarding, discarding_next;

  logic        cfg_wr;
  logic        accept;
  logic        can_load;
  logic [2:0]  n;
  logic [6:0]  v;
  logic [23:0] gbe, gbd, t;
  logic [2:0]  nres;
  logic        sp_nd, sp_bad;
  b64_pkg::load_t load_data;

  assign pready = 1'b1;
  assign prdata = {31'd0, decode_mode};
  assign cfg_wr = psel && penable && pwrite && paddr[2] == 1'b0;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  assign n   = {1'b0, group_count} + 3'd1;
  assign v   = b64_pkg::char_value(in_ch.in_byte);
  assign gbe = {group_bits[15:0], in_ch.in_byte};
  assign gbd = {group_bits[17:0], v[5:0]};

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    discarding_next  = discarding;
    t      = 24'd0;
    nres   = 3'd0;
    sp_nd  = 1'b0;
    sp_bad = 1'b0;
    if (!decode_mode) begin
      group_bits_next = gbe;
      if (n == 3'd3) begin
        t = gbe;
        nres = 3'd4;
        group_bits_next = 24'd0;
        group_count_next = 2'd0;
      end else if (in_ch.in_last) begin
        t = (n == 3'd1) ? {gbe[7:0], 16'h0000} : {gbe[15:0], 8'h00};
        nres = n + 3'd1;
        group_bits_next = 24'd0;
        group_count_next = 2'd0;
      end else begin
        group_count_next = n[1:0];
      end
    end else if (discarding) begin
      if (in_ch.in_last) begin
        discarding_next = 1'b0;
        group_bits_next = 24'd0;
        group_count_next = 2'd0;
      end
    end else if (v[6]) begin
      nres = 3'd1;
      sp_nd = 1'b1;
      sp_bad = 1'b1;
      group_bits_next = 24'd0;
      group_count_next = 2'd0;
      discarding_next = !in_ch.in_last;
    end else begin
      group_bits_next = gbd;
      if (n == 3'd4) begin
        t = gbd;
        nres = 3'd3;
        group_bits_next = 24'd0;
        group_count_next = 2'd0;
      end else if (in_ch.in_last) begin
        group_bits_next = 24'd0;
        group_count_next = 2'd0;
        if (n == 3'd1) begin
          nres = 3'd1;
          sp_nd = 1'b1;
        end else begin
          t = (n == 3'd2) ? {gbd[11:0], 12'h000} : {gbd[17:0], 6'h00};
          nres = n - 3'd1;
        end
      end else begin
        group_count_next = n[1:0];
      end
    end
  end

  always_comb begin
    load_data.cnt      = nres;
    load_data.last     = in_ch.in_last || sp_nd;
    load_data.no_data  = sp_nd;
    load_data.bad_char = sp_bad;
    if (sp_nd) begin
      load_data.bytes = 32'd0;
    end else if (!decode_mode) begin
      load_data.bytes = {b64_pkg::enc_char(t[23:18]), b64_pkg::enc_char(t[17:12]),
                         b64_pkg::enc_char(t[11:6]), b64_pkg::enc_char(t[5:0])};
    end else begin
      load_data.bytes = {t, 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      discarding  <= 1'b0;
    end else if (cfg_wr) begin
      decode_mode <= pwdata[0];
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      discarding  <= 1'b0;
    end else if (accept) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      discarding  <= discarding_next;
    end
  end

  b64_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && !cfg_wr && nres != 3'd0),
    .load_data (load_data),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

### rtl/b64_check.sv
// checker: port-level assertions on the codec result channel
`timescale 1ns / 1ps
module b64_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       no_data,
  input logic       bad_char
);

  a_nodata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_data |-> out_byte == 8'd0 && out_last)
    else $error("no_data word carries a byte or does not end the message");

  a_bad_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> no_data && out_last)
    else $error("bad_char word is not a bare end word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result word changed");

endmodule

bind base64_unpadded_codec b64_check u_b64_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last),
  .no_data   (out_ch.no_data),
  .bad_char  (out_ch.bad_char)
);

### tb/sv/base64_unpadded_codec_tb.sv
// testbench for the base64 codec: directed and random messages checked by a scoreboard
`timescale 1ns / 1ps
package b64_tb_pkg;

  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int  NO_VALUE    = 64;
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam int  MAX_REPORTS = 30;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       no_data;
    logic       bad_char;
  } codec_word_t;

  class codec_scoreboard;
    logic        decode_mode;
    logic [23:0] group_bits;
    int          group_count;
    logic        discarding;
    codec_word_t expected_words[$];
    int          mismatches;

    function new();
      mismatches = 0;
      set_mode(MODE_ENCODE);
    endfunction

    function void set_mode(logic m);
      decode_mode = m;
      group_bits  = '0;
      group_count = 0;
      discarding  = 1'b0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [7:0] b, logic l, logic nd, logic bc);
      codec_word_t w;
      w.out_byte = b;
      w.out_last = l;
      w.no_data  = nd;
      w.bad_char = bc;
      expected_words.push_back(w);
    endfunction

    function int sextet_of(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (ALPHABET[i] == c) return i;
      end
      return NO_VALUE;
    endfunction

    function void note_item(logic [7:0] b, logic last);
      int n;
      int nout;
      int v;
      int idx;
      logic [23:0] t;
      n = group_count + 1;
      if (decode_mode == MODE_ENCODE) begin
        group_bits = {group_bits[15:0], b};
        if (n == 3) begin
          t = group_bits;
          nout = 4;
        end else if (last) begin
          t = (n == 1) ? group_bits << 16 : group_bits << 8;
          nout = n + 1;
        end else begin
          group_count = n;
          return;
        end
        for (int k = 0; k < nout; k++) begin
          idx = int'((t >> (18 - 6 * k)) & 24'h3f);
          push_word(ALPHABET[idx], last && (k == nout - 1), 1'b0, 1'b0);
        end
      end else begin
        if (discarding) begin
          if (last) begin
            discarding = 1'b0;
            group_bits = '0;
            group_count = 0;
          end
          return;
        end
        v = sextet_of(b);
        if (v == NO_VALUE) begin
          push_word(8'h00, 1'b1, 1'b1, 1'b1);
          group_bits = '0;
          group_count = 0;
          discarding = !last;
          return;
        end
        group_bits = {group_bits[17:0], v[5:0]};
        if (n == 4) begin
          t = group_bits;
          nout = 3;
        end else if (last) begin
          if (n == 1) begin
            push_word(8'h00, 1'b1, 1'b1, 1'b0);
            group_bits = '0;
            group_count = 0;
            return;
          end
          t = (n == 2) ? group_bits << 12 : group_bits << 6;
          nout = n - 1;
        end else begin
          group_count = n;
          return;
        end
        for (int k = 0; k < nout; k++) begin
          push_word(8'((t >> (16 - 8 * k)) & 24'hff), last && (k == nout - 1), 1'b0, 1'b0);
        end
      end
      group_bits = '0;
      group_count = 0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_word(codec_word_t got);
      codec_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("unexpected word: out_byte %0h", got.out_byte);
        return;
      end
      want = expected_words.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("out_last", {7'd0, want.out_last}, {7'd0, got.out_last});
      compare_field("no_data", {7'd0, want.no_data}, {7'd0, got.no_data});
      compare_field("bad_char", {7'd0, want.bad_char}, {7'd0, got.bad_char});
    endfunction
  endclass

endpackage

module base64_unpadded_codec_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 60;
  localparam int NUM_PHASES   = 6;
  localparam logic [b64_pkg::APB_AW-1:0] MODE_REG_ADDR  = 3'd0;
  localparam logic [b64_pkg::APB_AW-1:0] SPARE_REG_ADDR = 3'd4;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [b64_pkg::APB_AW-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  b64_in_if  in_ch ();
  b64_out_if out_ch ();

  b64_tb_pkg::codec_scoreboard sb = new();
  bit steady;
  bit hold_req;
  int cycle_count = 0;
  int items_sent = 0;
  logic current_mode;

  always #2 clk = ~clk;

  base64_unpadded_codec dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.in_byte, in_ch.in_last);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_word('{out_ch.out_byte, out_ch.out_last, out_ch.no_data, out_ch.bad_char});
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic apb_write(logic [b64_pkg::APB_AW-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic [b64_pkg::APB_AW-1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_mode_readback();
    logic [31:0] rdata;
    apb_read(MODE_REG_ADDR, rdata);
    if (rdata !== {31'b0, current_mode}) begin
      sb.mismatches++;
      $error("decode_mode: expected %0h, got %0h", current_mode, rdata);
    end
  endtask

  task automatic write_mode(logic m);
    drain();
    apb_write(MODE_REG_ADDR, {31'b0, m});
    sb.set_mode(m);
    current_mode = m;
    check_mode_readback();
  endtask

  task automatic send_item(logic [7:0] b, logic last);
    int gap;
    if (!steady && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  task automatic send_raw_message(int len);
    for (int i = 0; i < len; i++) send_item(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  task automatic send_text_message(int len, bit corrupt);
    int bad_pos;
    logic [7:0] c;
    bad_pos = corrupt ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == bad_pos) c = 8'($urandom_range(0, 255));
      else c = b64_tb_pkg::ALPHABET[$urandom_range(0, 63)];
      send_item(c, i == len - 1);
    end
  endtask

  initial begin
    logic phase_modes [NUM_PHASES];
    int phase_start;
    phase_modes = '{b64_tb_pkg::MODE_ENCODE, b64_tb_pkg::MODE_DECODE,
                    b64_tb_pkg::MODE_DECODE, b64_tb_pkg::MODE_ENCODE,
                    b64_tb_pkg::MODE_DECODE, b64_tb_pkg::MODE_ENCODE};
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    current_mode  = b64_tb_pkg::MODE_ENCODE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode: one, two and three byte groups, then a group cut by a mode write
    write_mode(b64_tb_pkg::MODE_ENCODE);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h4d, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h6e, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);

    // decode: full and partial groups, lone char, bad chars with and without last
    write_mode(b64_tb_pkg::MODE_DECODE);
    send_text("TWFu");
    send_text("+/9z");
    send_text("QUI");
    send_text("Q");
    send_item("=", 1'b0);
    send_item("b", 1'b1);
    send_item(8'h80, 1'b1);

    // write to an unused address leaves the mode alone
    drain();
    apb_write(SPARE_REG_ADDR, 32'hffff_ffff);
    check_mode_readback();

    // mode write while discarding starts a fresh message
    send_item("*", 1'b0);
    write_mode(b64_tb_pkg::MODE_DECODE);
    send_text("QQ");

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(phase_modes[p]);
      steady = (p == 3);
      if (p == 2) hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if (phase_modes[p] == b64_tb_pkg::MODE_ENCODE) send_raw_message($urandom_range(1, 9));
        else send_text_message($urandom_range(1, 12), $urandom_range(0, 99) < 15);
      end
    end
    steady = 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
